[rtl/core/sci_pkg.sv]
// ----------------------------------------------------------------------------
// Segment/circle intersection package
// Shared constants and helpers for the multiplier pipeline sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package sci_pkg;

   // Bits of the second operand that one multiplier stage consumes.
   localparam int MUL_DIGIT = 16;

   // Number of register stages of a multiplier whose second operand is width bits.
   function automatic int mul_stages(input int width);
      return (width + MUL_DIGIT - 1) / MUL_DIGIT;
   endfunction

endpackage

`default_nettype wire

[rtl/core/sci_delay.sv]
// ----------------------------------------------------------------------------
// Side-band delay line
// Carries a valid bit and its payload through a fixed number of registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sci_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   output logic [WIDTH-1:0]      out_data
);

   logic             valid_ff [DEPTH];
   logic [WIDTH-1:0] data_ff  [DEPTH];

   // The first register takes the incoming transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff[0] <= in_data;
   end

   // Remaining registers shift the transaction along.
   for (genvar k = 1; k < DEPTH; k++) begin : g_tap
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         data_ff[k] <= data_ff[k-1];
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

`default_nettype wire

[rtl/core/sci_mul.sv]
// ----------------------------------------------------------------------------
// Pipelined unsigned multiplier
// Multiplies one digit of the second operand per stage and accumulates.
// ----------------------------------------------------------------------------
`default_nettype none

module sci_mul
   import sci_pkg::*;
#(
   parameter int WA = 32,
   parameter int WB = 32
) (
   input  wire logic             clock,
   input  wire logic [WA-1:0]    a,
   input  wire logic [WB-1:0]    b,
   output logic [WA+WB-1:0]      p
);

   localparam int ND = mul_stages(WB);
   localparam int BP = ND * MUL_DIGIT;
   localparam int PW = WA + WB;

   logic [BP-1:0] b_pad;
   logic [WA-1:0] a_ff   [ND];
   logic [BP-1:0] b_ff   [ND];
   logic [PW-1:0] acc_ff [ND];

   assign b_pad = BP'(b);

   // First stage: lowest digit.
   always_ff @(posedge clock) begin
      a_ff[0]   <= a;
      b_ff[0]   <= b_pad;
      acc_ff[0] <= PW'(a) * PW'(b_pad[MUL_DIGIT-1:0]);
   end

   // Each later stage adds the next digit's partial product.
   for (genvar k = 1; k < ND; k++) begin : g_stage
      always_ff @(posedge clock) begin
         a_ff[k]   <= a_ff[k-1];
         b_ff[k]   <= b_ff[k-1];
         acc_ff[k] <= acc_ff[k-1]
                    + ((PW'(a_ff[k-1]) * PW'(b_ff[k-1][k*MUL_DIGIT +: MUL_DIGIT]))
                       << (k * MUL_DIGIT));
      end
   end

   assign p = acc_ff[ND-1];

endmodule

`default_nettype wire

[rtl/core/sci_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Produces floor(sqrt(radicand)), one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sci_sqrt #(
   parameter int SW = 66
) (
   input  wire logic            clock,
   input  wire logic [2*SW-1:0] radicand,
   output logic [SW-1:0]        root
);

   localparam int RW = SW + 2;
   localparam int XW = 2 * SW;

   logic [XW-1:0] x_ff   [SW];
   logic [RW-1:0] rem_ff [SW];
   logic [SW-1:0] q_ff   [SW];

   for (genvar k = 0; k < SW; k++) begin : g_stage
      logic [XW-1:0] x_prev;
      logic [RW-1:0] rem_prev;
      logic [SW-1:0] q_prev;
      logic [RW-1:0] rem_try;
      logic [RW-1:0] trial;

      if (k == 0) begin : g_first
         assign x_prev   = radicand;
         assign rem_prev = '0;
         assign q_prev   = '0;
      end else begin : g_next
         assign x_prev   = x_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign q_prev   = q_ff[k-1];
      end

      // Bring down two radicand bits and try the next root bit.
      assign rem_try = {rem_prev[RW-3:0], x_prev[XW-1 -: 2]};
      assign trial   = {q_prev, 2'b01};

      always_ff @(posedge clock) begin
         x_ff[k] <= x_prev << 2;
         if (rem_try >= trial) begin
            rem_ff[k] <= rem_try - trial;
            q_ff[k]   <= {q_prev[SW-2:0], 1'b1};
         end else begin
            rem_ff[k] <= rem_try;
            q_ff[k]   <= {q_prev[SW-2:0], 1'b0};
         end
      end
   end

   assign root = q_ff[SW-1];

endmodule

`default_nettype wire

[rtl/core/sci_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces one quotient bit per stage; the quotient must fit NQ bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sci_div #(
   parameter int QW = 66,
   parameter int NQ = 33
) (
   input  wire logic [NQ+QW-1:0] dividend,
   input  wire logic [QW-1:0]    divisor,
   input  wire logic             clock,
   output logic [NQ-1:0]         quotient,
   output logic [QW-1:0]         remainder
);

   logic [QW-1:0] rem_ff [NQ];
   logic [NQ-1:0] low_ff [NQ];
   logic [NQ-1:0] quo_ff [NQ];
   logic [QW-1:0] d_ff   [NQ];

   for (genvar k = 0; k < NQ; k++) begin : g_stage
      logic [QW-1:0] rem_prev;
      logic [NQ-1:0] low_prev;
      logic [NQ-1:0] quo_prev;
      logic [QW-1:0] d_prev;
      logic [QW:0]   rem_try;
      logic [QW:0]   rem_diff;
      logic          fits;

      if (k == 0) begin : g_first
         assign rem_prev = dividend[NQ+QW-1:NQ];
         assign low_prev = dividend[NQ-1:0];
         assign quo_prev = '0;
         assign d_prev   = divisor;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign low_prev = low_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign d_prev   = d_ff[k-1];
      end

      // Shift in the next dividend bit and subtract when the divisor fits.
      assign rem_try  = {rem_prev, low_prev[NQ-1]};
      assign rem_diff = rem_try - {1'b0, d_prev};
      assign fits     = rem_try >= {1'b0, d_prev};

      always_ff @(posedge clock) begin
         rem_ff[k] <= fits ? rem_diff[QW-1:0] : rem_try[QW-1:0];
         quo_ff[k] <= {quo_prev[NQ-2:0], fits};
         low_ff[k] <= low_prev << 1;
         d_ff[k]   <= d_prev;
      end
   end

   assign quotient  = quo_ff[NQ-1];
   assign remainder = rem_ff[NQ-1];

endmodule

`default_nettype wire

[rtl/core/segment_circle_intersection.sv]
// ----------------------------------------------------------------------------
// Segment/circle intersection
// Finds where a segment crosses a circle and reports the chosen point.
// ----------------------------------------------------------------------------
// A transaction enters whenever start is high and busy is low; busy is high
// only during reset, so one transaction can enter every cycle. Each result
// appears on the rsp_ ports for one cycle with rsp_strobe. The delay from
// request to result is set by the one-bit-per-stage square root and divider
// and the digit-serial multipliers. Results come back in order and cannot
// be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_circle_intersection
   import sci_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [COORD_WIDTH-1:0] req_start_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_start_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_end_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_end_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_centre_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_centre_y,
   input  wire logic        [COORD_WIDTH-2:0] req_radius,
   input  wire logic signed [COORD_WIDTH-1:0] req_prior_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_prior_y,
   output logic                               rsp_strobe,
   output logic                               rsp_hit,
   output logic signed [COORD_WIDTH-1:0]      rsp_point_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_point_y
);

   localparam int W   = COORD_WIDTH;
   localparam int MW  = W + 1;
   localparam int QW  = 2 * W + 2;
   localparam int DW2 = 2 * QW;
   localparam int FS  = QW + 1;
   localparam int NS  = QW + 2;
   localparam int L1  = mul_stages(MW);
   localparam int L2  = mul_stages(QW);
   localparam int LAT = 10 + 3 * L1 + L2 + QW + MW;

   assign busy = reset;

   // ---------------- Stage A: capture the transaction ----------------
   logic                a_valid_ff;
   logic signed [W-1:0] a_sx_ff, a_sy_ff, a_ex_ff, a_ey_ff;
   logic signed [W-1:0] a_ox_ff, a_oy_ff, a_px_ff, a_py_ff;
   logic [W-2:0]        a_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      a_sx_ff <= req_start_x;
      a_sy_ff <= req_start_y;
      a_ex_ff <= req_end_x;
      a_ey_ff <= req_end_y;
      a_ox_ff <= req_centre_x;
      a_oy_ff <= req_centre_y;
      a_r_ff  <= req_radius;
      a_px_ff <= req_prior_x;
      a_py_ff <= req_prior_y;
   end

   // ---------------- Stage B: direction and offset vectors ----------------
   logic                 b_valid_ff;
   logic signed [MW-1:0] b_dx_ff, b_dy_ff, b_fx_ff, b_fy_ff;
   logic signed [W-1:0]  b_sx_ff, b_sy_ff, b_px_ff, b_py_ff;
   logic [W-2:0]         b_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_dx_ff <= MW'(a_ex_ff) - MW'(a_sx_ff);
      b_dy_ff <= MW'(a_ey_ff) - MW'(a_sy_ff);
      b_fx_ff <= MW'(a_sx_ff) - MW'(a_ox_ff);
      b_fy_ff <= MW'(a_sy_ff) - MW'(a_oy_ff);
      b_sx_ff <= a_sx_ff;
      b_sy_ff <= a_sy_ff;
      b_px_ff <= a_px_ff;
      b_py_ff <= a_py_ff;
      b_r_ff  <= a_r_ff;
   end

   // ---------------- Multiplier bank 1: squares and dot products ----------------
   logic [MW-1:0] b_dx_mag, b_dy_mag, b_fx_mag, b_fy_mag, b_r_ext;
   logic [QW-1:0] p_dxdx, p_dydy, p_fxdx, p_fydy, p_fxfx, p_fyfy, p_rr;

   assign b_dx_mag = b_dx_ff[MW-1] ? MW'(-b_dx_ff) : MW'(b_dx_ff);
   assign b_dy_mag = b_dy_ff[MW-1] ? MW'(-b_dy_ff) : MW'(b_dy_ff);
   assign b_fx_mag = b_fx_ff[MW-1] ? MW'(-b_fx_ff) : MW'(b_fx_ff);
   assign b_fy_mag = b_fy_ff[MW-1] ? MW'(-b_fy_ff) : MW'(b_fy_ff);
   assign b_r_ext  = MW'(b_r_ff);

   sci_mul #(.WA(MW), .WB(MW)) u_mul_dxdx (.clock, .a(b_dx_mag), .b(b_dx_mag), .p(p_dxdx));
   sci_mul #(.WA(MW), .WB(MW)) u_mul_dydy (.clock, .a(b_dy_mag), .b(b_dy_mag), .p(p_dydy));
   sci_mul #(.WA(MW), .WB(MW)) u_mul_fxdx (.clock, .a(b_fx_mag), .b(b_dx_mag), .p(p_fxdx));
   sci_mul #(.WA(MW), .WB(MW)) u_mul_fydy (.clock, .a(b_fy_mag), .b(b_dy_mag), .p(p_fydy));
   sci_mul #(.WA(MW), .WB(MW)) u_mul_fxfx (.clock, .a(b_fx_mag), .b(b_fx_mag), .p(p_fxfx));
   sci_mul #(.WA(MW), .WB(MW)) u_mul_fyfy (.clock, .a(b_fy_mag), .b(b_fy_mag), .p(p_fyfy));
   sci_mul #(.WA(MW), .WB(MW)) u_mul_rr   (.clock, .a(b_r_ext),  .b(b_r_ext),  .p(p_rr));

   localparam int SD1 = 2 * MW + 4 * W + 2;
   logic                 m1_valid;
   logic [SD1-1:0]       m1_data;
   logic signed [MW-1:0] m1_dx, m1_dy;
   logic signed [W-1:0]  m1_sx, m1_sy, m1_px, m1_py;
   logic                 m1_s1, m1_s2;

   sci_delay #(.WIDTH(SD1), .DEPTH(L1)) u_dly1 (
      .clock, .reset,
      .in_valid (b_valid_ff),
      .in_data  ({b_dx_ff, b_dy_ff, b_sx_ff, b_sy_ff, b_px_ff, b_py_ff,
                  b_fx_ff[MW-1] ^ b_dx_ff[MW-1], b_fy_ff[MW-1] ^ b_dy_ff[MW-1]}),
      .out_valid(m1_valid),
      .out_data (m1_data)
   );
   assign {m1_dx, m1_dy, m1_sx, m1_sy, m1_px, m1_py, m1_s1, m1_s2} = m1_data;

   // ---------------- Stage C: quadratic coefficients ----------------
   logic                 c_valid_ff;
   logic [QW-1:0]        c_dd_ff, c_ff_ff, c_r2_ff;
   logic signed [FS-1:0] c_fd_ff;
   logic signed [FS-1:0] c_t1, c_t2;
   logic signed [MW-1:0] c_dx_ff, c_dy_ff;
   logic signed [W-1:0]  c_sx_ff, c_sy_ff, c_px_ff, c_py_ff;

   assign c_t1 = signed'(FS'(p_fxdx));
   assign c_t2 = signed'(FS'(p_fydy));

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= m1_valid;
      end
   end

   always_ff @(posedge clock) begin
      c_dd_ff <= p_dxdx + p_dydy;
      c_fd_ff <= (m1_s1 ? -c_t1 : c_t1) + (m1_s2 ? -c_t2 : c_t2);
      c_ff_ff <= p_fxfx + p_fyfy;
      c_r2_ff <= p_rr;
      c_dx_ff <= m1_dx;
      c_dy_ff <= m1_dy;
      c_sx_ff <= m1_sx;
      c_sy_ff <= m1_sy;
      c_px_ff <= m1_px;
      c_py_ff <= m1_py;
   end

   // ---------------- Stage D: constant term and magnitudes ----------------
   logic                 d_valid_ff;
   logic signed [FS-1:0] d_c_in;
   logic [QW-1:0]        d_fdmag_ff, d_cmag_ff, d_dd_ff;
   logic                 d_cneg_ff;
   logic signed [FS-1:0] d_fd_ff;
   logic signed [MW-1:0] d_dx_ff, d_dy_ff;
   logic signed [W-1:0]  d_sx_ff, d_sy_ff, d_px_ff, d_py_ff;

   assign d_c_in = signed'(FS'(c_ff_ff)) - signed'(FS'(c_r2_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_fdmag_ff <= c_fd_ff[FS-1] ? QW'(-c_fd_ff) : QW'(c_fd_ff);
      d_cmag_ff  <= d_c_in[FS-1] ? QW'(-d_c_in) : QW'(d_c_in);
      d_cneg_ff  <= d_c_in[FS-1];
      d_fd_ff    <= c_fd_ff;
      d_dd_ff    <= c_dd_ff;
      d_dx_ff    <= c_dx_ff;
      d_dy_ff    <= c_dy_ff;
      d_sx_ff    <= c_sx_ff;
      d_sy_ff    <= c_sy_ff;
      d_px_ff    <= c_px_ff;
      d_py_ff    <= c_py_ff;
   end

   // ---------------- Multiplier bank 2: discriminant terms ----------------
   logic [DW2-1:0] p_fd2, p_ddc;

   sci_mul #(.WA(QW), .WB(QW)) u_mul_fd2 (.clock, .a(d_fdmag_ff), .b(d_fdmag_ff), .p(p_fd2));
   sci_mul #(.WA(QW), .WB(QW)) u_mul_ddc (.clock, .a(d_dd_ff),    .b(d_cmag_ff),  .p(p_ddc));

   localparam int SD2 = FS + 1 + QW + 2 * MW + 4 * W;
   logic                 m2_valid;
   logic [SD2-1:0]       m2_data;
   logic signed [FS-1:0] m2_fd;
   logic                 m2_cneg;
   logic [QW-1:0]        m2_dd;
   logic signed [MW-1:0] m2_dx, m2_dy;
   logic signed [W-1:0]  m2_sx, m2_sy, m2_px, m2_py;

   sci_delay #(.WIDTH(SD2), .DEPTH(L2)) u_dly2 (
      .clock, .reset,
      .in_valid (d_valid_ff),
      .in_data  ({d_fd_ff, d_cneg_ff, d_dd_ff, d_dx_ff, d_dy_ff,
                  d_sx_ff, d_sy_ff, d_px_ff, d_py_ff}),
      .out_valid(m2_valid),
      .out_data (m2_data)
   );
   assign {m2_fd, m2_cneg, m2_dd, m2_dx, m2_dy, m2_sx, m2_sy, m2_px, m2_py} = m2_data;

   // ---------------- Stage E: discriminant ----------------
   logic           e_valid_ff;
   logic [DW2:0]   e_sum;
   logic [DW2-1:0] e_disc_in, e_disc_ff;
   logic           e_real_in, e_real_ff, e_tan_ff;
   logic signed [FS-1:0] e_fd_ff;
   logic [QW-1:0]        e_dd_ff;
   logic signed [MW-1:0] e_dx_ff, e_dy_ff;
   logic signed [W-1:0]  e_sx_ff, e_sy_ff, e_px_ff, e_py_ff;

   assign e_sum     = (DW2+1)'(p_fd2) + (DW2+1)'(p_ddc);
   assign e_real_in = m2_cneg || (p_fd2 >= p_ddc);
   assign e_disc_in = m2_cneg ? e_sum[DW2-1:0] : p_fd2 - p_ddc;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= m2_valid;
      end
   end

   always_ff @(posedge clock) begin
      e_disc_ff <= e_disc_in;
      e_real_ff <= e_real_in;
      e_tan_ff  <= (e_disc_in == '0);
      e_fd_ff   <= m2_fd;
      e_dd_ff   <= m2_dd;
      e_dx_ff   <= m2_dx;
      e_dy_ff   <= m2_dy;
      e_sx_ff   <= m2_sx;
      e_sy_ff   <= m2_sy;
      e_px_ff   <= m2_px;
      e_py_ff   <= m2_py;
   end

   // ---------------- Square root of the discriminant ----------------
   logic [QW-1:0] s_root;

   sci_sqrt #(.SW(QW)) u_sqrt (.clock, .radicand(e_disc_ff), .root(s_root));

   localparam int SD3 = 2 + FS + QW + 2 * MW + 4 * W;
   logic                 s_valid;
   logic [SD3-1:0]       s_data;
   logic                 s_real, s_tan;
   logic signed [FS-1:0] s_fd;
   logic [QW-1:0]        s_dd;
   logic signed [MW-1:0] s_dx, s_dy;
   logic signed [W-1:0]  s_sx, s_sy, s_px, s_py;

   sci_delay #(.WIDTH(SD3), .DEPTH(QW)) u_dly3 (
      .clock, .reset,
      .in_valid (e_valid_ff),
      .in_data  ({e_real_ff, e_tan_ff, e_fd_ff, e_dd_ff, e_dx_ff, e_dy_ff,
                  e_sx_ff, e_sy_ff, e_px_ff, e_py_ff}),
      .out_valid(s_valid),
      .out_data (s_data)
   );
   assign {s_real, s_tan, s_fd, s_dd, s_dx, s_dy, s_sx, s_sy, s_px, s_py} = s_data;

   // ---------------- Stage F: root numerators ----------------
   logic                 f_valid_ff;
   logic signed [NS-1:0] f_negfd, f_q;
   logic signed [NS-1:0] f_nhi_ff, f_nlo_ff;
   logic                 f_real_ff, f_tan_ff, f_dir_ff;
   logic [QW-1:0]        f_dd_ff;
   logic signed [MW-1:0] f_dx_ff, f_dy_ff;
   logic signed [W-1:0]  f_sx_ff, f_sy_ff, f_px_ff, f_py_ff;

   assign f_negfd = -NS'(s_fd);
   assign f_q     = signed'(NS'(s_root));

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= s_valid;
      end
   end

   always_ff @(posedge clock) begin
      f_nhi_ff  <= f_negfd + f_q;
      f_nlo_ff  <= f_negfd - f_q;
      f_real_ff <= s_real;
      f_tan_ff  <= s_tan;
      f_dir_ff  <= (s_dx > 0) || ((s_dx == 0) && (s_dy > 0));
      f_dd_ff   <= s_dd;
      f_dx_ff   <= s_dx;
      f_dy_ff   <= s_dy;
      f_sx_ff   <= s_sx;
      f_sy_ff   <= s_sy;
      f_px_ff   <= s_px;
      f_py_ff   <= s_py;
   end

   // ---------------- Stage G: root ordering and on-segment test ----------------
   logic                 g_valid_ff;
   logic signed [NS-1:0] g_first, g_second, g_dd_s;
   logic                 g_on1, g_on2;
   logic [QW-1:0]        g_n_ff, g_dd_ff;
   logic                 g_use_ff, g_real_ff;
   logic signed [MW-1:0] g_dx_ff, g_dy_ff;
   logic signed [W-1:0]  g_sx_ff, g_sy_ff, g_px_ff, g_py_ff;

   // A tangent has one root, used for both candidates.
   assign g_second = f_dir_ff ? f_nlo_ff : f_nhi_ff;
   assign g_first  = f_tan_ff ? g_second : (f_dir_ff ? f_nhi_ff : f_nlo_ff);
   assign g_dd_s   = signed'(NS'(f_dd_ff));
   assign g_on2    = !g_second[NS-1] && (g_second <= g_dd_s);
   assign g_on1    = !g_first[NS-1] && (g_first <= g_dd_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else begin
         g_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      g_n_ff    <= g_on2 ? QW'(g_second) : QW'(g_first);
      g_use_ff  <= f_real_ff && (f_dd_ff != '0) && (g_on1 || g_on2);
      g_real_ff <= f_real_ff;
      g_dd_ff   <= f_dd_ff;
      g_dx_ff   <= f_dx_ff;
      g_dy_ff   <= f_dy_ff;
      g_sx_ff   <= f_sx_ff;
      g_sy_ff   <= f_sy_ff;
      g_px_ff   <= f_px_ff;
      g_py_ff   <= f_py_ff;
   end

   // ---------------- Multiplier bank 3: scaled direction ----------------
   logic [MW-1:0]    g_dx_mag, g_dy_mag;
   logic [QW+MW-1:0] p_xn, p_yn;

   assign g_dx_mag = g_dx_ff[MW-1] ? MW'(-g_dx_ff) : MW'(g_dx_ff);
   assign g_dy_mag = g_dy_ff[MW-1] ? MW'(-g_dy_ff) : MW'(g_dy_ff);

   sci_mul #(.WA(QW), .WB(MW)) u_mul_xn (.clock, .a(g_n_ff), .b(g_dx_mag), .p(p_xn));
   sci_mul #(.WA(QW), .WB(MW)) u_mul_yn (.clock, .a(g_n_ff), .b(g_dy_mag), .p(p_yn));

   localparam int SD4 = 4 + QW + 4 * W;
   logic                m3_valid;
   logic [SD4-1:0]      m3_data;
   logic                m3_use, m3_real, m3_negx, m3_negy;
   logic [QW-1:0]       m3_dd;
   logic signed [W-1:0] m3_sx, m3_sy, m3_px, m3_py;

   sci_delay #(.WIDTH(SD4), .DEPTH(L1)) u_dly4 (
      .clock, .reset,
      .in_valid (g_valid_ff),
      .in_data  ({g_use_ff, g_real_ff, g_dx_ff[MW-1], g_dy_ff[MW-1], g_dd_ff,
                  g_sx_ff, g_sy_ff, g_px_ff, g_py_ff}),
      .out_valid(m3_valid),
      .out_data (m3_data)
   );
   assign {m3_use, m3_real, m3_negx, m3_negy, m3_dd, m3_sx, m3_sy, m3_px, m3_py} = m3_data;

   // ---------------- Dividers: placement along the segment ----------------
   logic [MW-1:0] v_qx, v_qy;
   logic [QW-1:0] v_rx, v_ry;

   sci_div #(.QW(QW), .NQ(MW)) u_div_x (
      .clock, .dividend(p_xn), .divisor(m3_dd), .quotient(v_qx), .remainder(v_rx)
   );
   sci_div #(.QW(QW), .NQ(MW)) u_div_y (
      .clock, .dividend(p_yn), .divisor(m3_dd), .quotient(v_qy), .remainder(v_ry)
   );

   logic                v_valid;
   logic [SD4-1:0]      v_data;
   logic                v_use, v_real, v_negx, v_negy;
   logic [QW-1:0]       v_dd;
   logic signed [W-1:0] v_sx, v_sy, v_px, v_py;

   sci_delay #(.WIDTH(SD4), .DEPTH(MW)) u_dly5 (
      .clock, .reset,
      .in_valid (m3_valid),
      .in_data  (m3_data),
      .out_valid(v_valid),
      .out_data (v_data)
   );
   assign {v_use, v_real, v_negx, v_negy, v_dd, v_sx, v_sy, v_px, v_py} = v_data;

   // ---------------- Stage H: round to nearest and place the point ----------------
   logic                 h_valid_ff;
   logic [MW-1:0]        h_qvx, h_qvy;
   logic signed [MW-1:0] h_offx, h_offy;
   logic signed [MW-1:0] h_ptx, h_pty;
   logic signed [W-1:0]  h_px_ff, h_py_ff, h_sx_ff, h_sy_ff;
   logic [QW-1:0]        h_dd_ff;
   logic                 h_real_ff;

   assign h_qvx  = v_qx + MW'(((QW+1)'(v_rx) << 1) >= (QW+1)'(v_dd));
   assign h_qvy  = v_qy + MW'(((QW+1)'(v_ry) << 1) >= (QW+1)'(v_dd));
   assign h_offx = v_negx ? -signed'(h_qvx) : signed'(h_qvx);
   assign h_offy = v_negy ? -signed'(h_qvy) : signed'(h_qvy);
   assign h_ptx  = MW'(v_sx) + h_offx;
   assign h_pty  = MW'(v_sy) + h_offy;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else begin
         h_valid_ff <= v_valid;
      end
   end

   always_ff @(posedge clock) begin
      h_px_ff   <= v_use ? W'(h_ptx) : v_px;
      h_py_ff   <= v_use ? W'(h_pty) : v_py;
      h_sx_ff   <= v_sx;
      h_sy_ff   <= v_sy;
      h_dd_ff   <= v_dd;
      h_real_ff <= v_real;
   end

   // ---------------- Stage I: offset of the chosen point ----------------
   logic                 i_valid_ff;
   logic signed [MW-1:0] i_ox_ff, i_oy_ff;
   logic signed [W-1:0]  i_px_ff, i_py_ff;
   logic [QW-1:0]        i_dd_ff;
   logic                 i_real_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
      end else begin
         i_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      i_ox_ff   <= MW'(h_px_ff) - MW'(h_sx_ff);
      i_oy_ff   <= MW'(h_py_ff) - MW'(h_sy_ff);
      i_px_ff   <= h_px_ff;
      i_py_ff   <= h_py_ff;
      i_dd_ff   <= h_dd_ff;
      i_real_ff <= h_real_ff;
   end

   // ---------------- Multiplier bank 4: squared distance ----------------
   logic [MW-1:0] i_ox_mag, i_oy_mag;
   logic [QW-1:0] p_oxox, p_oyoy;

   assign i_ox_mag = i_ox_ff[MW-1] ? MW'(-i_ox_ff) : MW'(i_ox_ff);
   assign i_oy_mag = i_oy_ff[MW-1] ? MW'(-i_oy_ff) : MW'(i_oy_ff);

   sci_mul #(.WA(MW), .WB(MW)) u_mul_oxox (.clock, .a(i_ox_mag), .b(i_ox_mag), .p(p_oxox));
   sci_mul #(.WA(MW), .WB(MW)) u_mul_oyoy (.clock, .a(i_oy_mag), .b(i_oy_mag), .p(p_oyoy));

   localparam int SD6 = 1 + QW + 2 * W;
   logic                m4_valid;
   logic [SD6-1:0]      m4_data;
   logic                m4_real;
   logic [QW-1:0]       m4_dd;
   logic signed [W-1:0] m4_px, m4_py;

   sci_delay #(.WIDTH(SD6), .DEPTH(L1)) u_dly6 (
      .clock, .reset,
      .in_valid (i_valid_ff),
      .in_data  ({i_real_ff, i_dd_ff, i_px_ff, i_py_ff}),
      .out_valid(m4_valid),
      .out_data (m4_data)
   );
   assign {m4_real, m4_dd, m4_px, m4_py} = m4_data;

   // ---------------- Stage J: hit test and result register ----------------
   // A line that misses the circle never reports a hit.
   logic                rsp_strobe_ff;
   logic                rsp_hit_ff;
   logic signed [W-1:0] rsp_point_x_ff, rsp_point_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= m4_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff     <= m4_real
                        && (((QW+1)'(p_oxox) + (QW+1)'(p_oyoy)) < (QW+1)'(m4_dd));
      rsp_point_x_ff <= m4_px;
      rsp_point_y_ff <= m4_py;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_point_x = rsp_point_x_ff;
   assign rsp_point_y = rsp_point_y_ff;

   // ---------------- Assertions ----------------
   // Every accepted transaction produces its result after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("result missing after accepted transaction");

   // No result appears without a matching accepted transaction.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without a matching transaction");

   // A zero-length segment never reports a hit.
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      (m4_valid && (m4_dd == '0)) |=> !rsp_hit)
      else $error("hit reported for zero-length segment");

endmodule

`default_nettype wire
